### hw/rtl/c8x_pkg.sv
package c8x_pkg;

   localparam logic [1:0] ACT_EXEC  = 2'd0;
   localparam logic [1:0] ACT_WRITE = 2'd1;
   localparam logic [1:0] ACT_READ  = 2'd2;
   localparam logic [1:0] ACT_ROW   = 2'd3;

   // datapath commands
   localparam logic [3:0] CMD_NONE     = 4'd0;
   localparam logic [3:0] CMD_LATCH    = 4'd1;  // capture request, read VX/VY
   localparam logic [3:0] CMD_EXEC     = 4'd2;  // opcode effects in the dispatch state
   localparam logic [3:0] CMD_MEMWR    = 4'd3;  // write mem_addr
   localparam logic [3:0] CMD_MEMRD    = 4'd4;  // issue memory read at address
   localparam logic [3:0] CMD_ROWRD    = 4'd5;
   localparam logic [3:0] CMD_CLS      = 4'd6;  // clear one frame row
   localparam logic [3:0] CMD_DRAWRD   = 4'd7;  // read sprite byte + frame row
   localparam logic [3:0] CMD_DRAWWR   = 4'd8;  // write back frame row
   localparam logic [3:0] CMD_STORE    = 4'd9;  // FX55 one byte / BCD digit
   localparam logic [3:0] CMD_LOADRD   = 4'd10; // FX65 read
   localparam logic [3:0] CMD_LOADWR   = 4'd11; // FX65 reg write
   localparam logic [3:0] CMD_FILL     = 4'd12; // clear/font fill after reset
   localparam logic [3:0] CMD_RESULT   = 4'd13;

   typedef struct packed {
      logic [3:0] cmd;
      logic [6:0] step;
   } cmd_type;

   typedef struct packed {
      logic [1:0] action;
      logic [3:0] top;
      logic [3:0] x;
      logic [3:0] n;
      logic [7:0] kk;
      logic       row_clip;  // current draw row beyond bottom edge
      logic       fill_last; // fill pass at the last memory address
   } status_type;

   function automatic logic [7:0] glyph(input logic [6:0] i);
      logic [7:0] g;
      case (i)
         7'd0,7'd4,7'd10,7'd12,7'd14,7'd15,7'd17,7'd19,7'd22,7'd25,7'd27,7'd29,
         7'd30,7'd32,7'd34,7'd35,7'd40,7'd42,7'd44,7'd45,7'd47,7'd49,7'd50,7'd52,
         7'd60,7'd64,7'd70,7'd72,7'd74,7'd75,7'd77: g = 8'hF0;
         7'd1,7'd2,7'd3,7'd20,7'd21,7'd33,7'd41,7'd43,7'd46,7'd51,7'd53,7'd54,
         7'd56,7'd58,7'd66,7'd67,7'd68: g = 8'h90;
         7'd5,7'd7,7'd8,7'd37: g = 8'h20;
         7'd6: g = 8'h60;
         7'd9: g = 8'h70;
         7'd11,7'd16,7'd18,7'd23,7'd24,7'd28,7'd36,7'd48: g = 8'h10;
         7'd13,7'd26,7'd31,7'd61,7'd62,7'd63,7'd71,7'd73,7'd76,7'd78,7'd79: g = 8'h80;
         7'd38,7'd39: g = 8'h40;
         7'd55,7'd57,7'd59,7'd65,7'd69: g = 8'hE0;
         default: g = 8'h00;
      endcase
      return g;
   endfunction

endpackage

### hw/rtl/chip8_instruction_executor_top.sv
// CHIP-8 interpreter core.
// Request channel (req_valid/req_ready): one action per request: execute an
// opcode, write or read a memory byte, or read a 64-bit display row.
// Result channel (rsp_valid/rsp_ready): one result per request carrying PC,
// I, VF, key-wait status, sound-active and read data.
// Simple opcodes and memory writes go from dispatch straight to the result;
// memory and row reads pass a wait and a result step; clear-screen clears the
// 32 rows in turn; draw reads, then writes back, each sprite row and stops at
// a row past the bottom edge; FX55 and BCD store, and FX65 loads, byte by byte.
// One request is in flight at a time, set by the single memory port that the
// draw and block moves walk byte by byte.
// A new request is taken from the cycle after the previous result has been
// delivered, so a stalled receiver holds the block.
// After reset the memory is cleared and the font written at FONT_BASE in one
// pass over all 4096 addresses with req_ready low. Registers, PC, I, timers and
// frame reset at once.
module chip8_instruction_executor_top #(
   parameter int STACK_DEPTH   = 16,
   parameter int PROGRAM_START = 512,
   parameter int FONT_BASE     = 80
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_action,
   input  logic [15:0] req_opcode,
   input  logic [15:0] req_keys_down,
   input  logic [7:0]  req_random_byte,
   input  logic [11:0] req_mem_addr,
   input  logic [7:0]  req_mem_data,
   input  logic [4:0]  req_row_select,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [11:0] rsp_pc_now,
   output logic [15:0] rsp_index_now,
   output logic [7:0]  rsp_flag_now,
   output logic        rsp_awaiting_key,
   output logic        rsp_sound_on,
   output logic [63:0] rsp_read_data
);
   c8x_pkg::cmd_type    cmd;
   c8x_pkg::status_type status;

   c8x_control u_ctl (.clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .cmd, .status);

   c8x_datapath #(.STACK_DEPTH(STACK_DEPTH), .PROGRAM_START(PROGRAM_START),
      .FONT_BASE(FONT_BASE)) u_dp (
      .clock, .reset, .cmd, .status, .req_action, .req_opcode, .req_keys_down,
      .req_random_byte, .req_mem_addr, .req_mem_data, .req_row_select,
      .pc_now(rsp_pc_now), .index_now(rsp_index_now), .flag_now(rsp_flag_now),
      .awaiting_key(rsp_awaiting_key), .sound_on(rsp_sound_on),
      .read_data(rsp_read_data));
endmodule

### hw/rtl/c8x_datapath.sv
module c8x_datapath #(
   parameter int STACK_DEPTH   = 16,
   parameter int PROGRAM_START = 512,
   parameter int FONT_BASE     = 80
) (
   input  logic                clock,
   input  logic                reset,
   input  c8x_pkg::cmd_type    cmd,
   output c8x_pkg::status_type status,
   input  logic [1:0]          req_action,
   input  logic [15:0]         req_opcode,
   input  logic [15:0]         req_keys_down,
   input  logic [7:0]          req_random_byte,
   input  logic [11:0]         req_mem_addr,
   input  logic [7:0]          req_mem_data,
   input  logic [4:0]          req_row_select,
   output logic [11:0]         pc_now,
   output logic [15:0]         index_now,
   output logic [7:0]          flag_now,
   output logic                awaiting_key,
   output logic                sound_on,
   output logic [63:0]         read_data
);
   localparam int SW = $clog2(STACK_DEPTH);

   logic [7:0]  mem [4096];
   logic [63:0] frame [32];
   logic [7:0]  regs_ff [16];
   logic [11:0] stk [STACK_DEPTH];

   logic [1:0]  act_ff;
   logic [15:0] op_ff, keys_ff;
   logic [7:0]  rnd_ff, mdat_ff;
   logic [11:0] maddr_ff;
   logic [4:0]  row_ff;
   logic [7:0]  vx_ff, vy_ff;
   logic [11:0] pc_ff;
   logic [15:0] idx_ff;
   logic [SW-1:0] sp_ff;
   logic [7:0]  dly_ff, snd_ff;
   logic        wait_ff;
   logic [63:0] rd_ff;
   logic [7:0]  mrd_ff;
   logic [63:0] frd_ff;
   logic [4:0]  py_ff;
   logic [11:0] fill_ff;
   logic [11:0] font_off;
   logic [7:0]  bcd_h, bcd_t, bcd_o, bcd_r;
   logic [15:0] bcd_p;

   logic [3:0] x, y, n;
   logic [7:0] kk;
   assign x  = op_ff[11:8];
   assign y  = op_ff[7:4];
   assign n  = op_ff[3:0];
   assign kk = op_ff[7:0];

   assign status.action    = act_ff;
   assign status.top       = op_ff[15:12];
   assign status.x         = x;
   assign status.n         = n;
   assign status.kk        = kk;
   assign status.row_clip  = ({1'b0, vy_ff[4:0]} + {2'b0, cmd.step[3:0]}) > 6'd31;
   assign status.fill_last = fill_ff == 12'hFFF;

   assign font_off = fill_ff - 12'(FONT_BASE);

   // BCD by compare-subtract for hundreds, reciprocal multiply for tens
   always_comb begin
      if (vx_ff >= 8'd200) begin
         bcd_h = 8'd2;
         bcd_r = vx_ff - 8'd200;
      end else if (vx_ff >= 8'd100) begin
         bcd_h = 8'd1;
         bcd_r = vx_ff - 8'd100;
      end else begin
         bcd_h = 8'd0;
         bcd_r = vx_ff;
      end
      bcd_p = {8'd0, bcd_r} * 16'd205;
      bcd_t = {3'd0, bcd_p[15:11]};
      bcd_o = bcd_r - ({bcd_t[4:0], 3'd0} + {bcd_t[6:0], 1'b0});
   end

   // sprite byte shifted to screen position, clipped at the right edge
   logic [63:0] spr;
   assign spr = {mrd_ff, 56'd0} >> vx_ff[5:0];

   logic [11:0] pc2;
   assign pc2 = pc_ff + 12'd2;
   logic [4:0] keyi;
   logic       keyf;
   always_comb begin
      keyi = 5'd0;
      keyf = 1'b0;
      for (int i = 15; i >= 0; i--)
         if (keys_ff[i]) begin
            keyi = 5'(i);
            keyf = 1'b1;
         end
   end

   logic [11:0] maddr;
   always_comb begin
      case (cmd.cmd)
         c8x_pkg::CMD_MEMRD, c8x_pkg::CMD_MEMWR: maddr = maddr_ff;
         c8x_pkg::CMD_FILL:  maddr = fill_ff;
         default:            maddr = idx_ff[11:0] + 12'(cmd.step);
      endcase
   end

   // memory
   always_ff @(posedge clock) begin
      case (cmd.cmd)
         c8x_pkg::CMD_FILL:
            mem[maddr] <= (font_off < 12'd80) ? c8x_pkg::glyph(font_off[6:0]) : 8'd0;
         c8x_pkg::CMD_MEMWR: mem[maddr] <= mdat_ff;
         c8x_pkg::CMD_STORE: begin
            if (status.top == 4'hF && kk == 8'h33)
               mem[maddr] <= (cmd.step == 7'd0) ? bcd_h :
                             (cmd.step == 7'd1) ? bcd_t : bcd_o;
            else
               mem[maddr] <= regs_ff[cmd.step[3:0]];
         end
         c8x_pkg::CMD_MEMRD, c8x_pkg::CMD_DRAWRD, c8x_pkg::CMD_LOADRD:
            mrd_ff <= mem[maddr];
         default: ;
      endcase
   end

   // frame
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 32; i++) frame[i] <= 64'd0;
      end else begin
         case (cmd.cmd)
            c8x_pkg::CMD_CLS:    frame[cmd.step[4:0]] <= 64'd0;
            c8x_pkg::CMD_DRAWWR: frame[py_ff] <= frd_ff ^ spr;
            c8x_pkg::CMD_DRAWRD: begin
               frd_ff <= frame[vy_ff[4:0] + cmd.step[4:0]];
               py_ff  <= vy_ff[4:0] + cmd.step[4:0];
            end
            c8x_pkg::CMD_ROWRD: frd_ff <= frame[row_ff];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.cmd == c8x_pkg::CMD_EXEC && op_ff[15:12] == 4'h2) stk[sp_ff] <= pc_ff;
   end

   always_ff @(posedge clock) begin
      if (cmd.cmd == c8x_pkg::CMD_LATCH) begin
         act_ff <= req_action; op_ff <= req_opcode; keys_ff <= req_keys_down;
         rnd_ff <= req_random_byte; maddr_ff <= req_mem_addr;
         mdat_ff <= req_mem_data; row_ff <= req_row_select;
         vx_ff <= regs_ff[req_opcode[11:8]];
         vy_ff <= regs_ff[req_opcode[7:4]];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 16; i++) regs_ff[i] <= 8'd0;
         pc_ff <= 12'(PROGRAM_START); idx_ff <= 16'd0; sp_ff <= '0;
         dly_ff <= 8'd0; snd_ff <= 8'd0; wait_ff <= 1'b0; rd_ff <= 64'd0;
         fill_ff <= 12'd0;
      end else begin
         case (cmd.cmd)
            c8x_pkg::CMD_FILL: fill_ff <= fill_ff + 12'd1;
            c8x_pkg::CMD_LATCH: begin
               wait_ff <= 1'b0;
               rd_ff   <= 64'd0;
               if (req_action == c8x_pkg::ACT_EXEC) pc_ff <= pc_ff + 12'd2;
            end
            c8x_pkg::CMD_EXEC: begin
               case (op_ff[15:12])
                  4'h0: if (op_ff == 16'h00EE) begin
                     sp_ff <= (sp_ff == '0) ? SW'(STACK_DEPTH - 1) : sp_ff - 1'b1;
                     pc_ff <= stk[(sp_ff == '0) ? SW'(STACK_DEPTH - 1) : sp_ff - 1'b1];
                  end
                  4'h1: pc_ff <= op_ff[11:0];
                  4'h2: begin
                     sp_ff <= (sp_ff == SW'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
                     pc_ff <= op_ff[11:0];
                  end
                  4'h3: if (vx_ff == kk) pc_ff <= pc2;
                  4'h4: if (vx_ff != kk) pc_ff <= pc2;
                  4'h5: if (n == 4'd0 && vx_ff == vy_ff) pc_ff <= pc2;
                  4'h6: regs_ff[x] <= kk;
                  4'h7: regs_ff[x] <= vx_ff + kk;
                  4'h8: case (n)
                     4'h0: regs_ff[x] <= vy_ff;
                     4'h1: regs_ff[x] <= vx_ff | vy_ff;
                     4'h2: regs_ff[x] <= vx_ff & vy_ff;
                     4'h3: regs_ff[x] <= vx_ff ^ vy_ff;
                     4'h4: begin
                        regs_ff[15] <= {7'd0, ({1'b0, vx_ff} + {1'b0, vy_ff}) > 9'hFF};
                        regs_ff[x]  <= vx_ff + vy_ff;
                     end
                     4'h5: begin
                        regs_ff[15] <= {7'd0, vx_ff > vy_ff};
                        regs_ff[x]  <= vx_ff - vy_ff;
                     end
                     4'h6: begin
                        regs_ff[15] <= {7'd0, vx_ff[0]};
                        regs_ff[x]  <= {1'b0, vx_ff[7:1]};
                     end
                     4'h7: begin
                        regs_ff[15] <= {7'd0, vy_ff > vx_ff};
                        regs_ff[x]  <= vy_ff - vx_ff;
                     end
                     4'hE: begin
                        regs_ff[15] <= {7'd0, vx_ff[7]};
                        regs_ff[x]  <= {vx_ff[6:0], 1'b0};
                     end
                     default: ;
                  endcase
                  4'h9: if (n == 4'd0 && vx_ff != vy_ff) pc_ff <= pc2;
                  4'hA: idx_ff <= {4'd0, op_ff[11:0]};
                  4'hB: pc_ff <= op_ff[11:0] + {4'd0, regs_ff[0]};
                  4'hC: regs_ff[x] <= rnd_ff & kk;
                  4'hD: regs_ff[15] <= 8'd0;
                  4'hE: begin
                     if (kk == 8'h9E && keys_ff[vx_ff[3:0]]) pc_ff <= pc2;
                     else if (kk == 8'hA1 && !keys_ff[vx_ff[3:0]]) pc_ff <= pc2;
                  end
                  default: case (kk)
                     8'h07: regs_ff[x] <= dly_ff;
                     8'h0A: if (keyf) regs_ff[x] <= {4'd0, keyi[3:0]};
                        else begin
                           pc_ff   <= pc_ff - 12'd2;
                           wait_ff <= 1'b1;
                        end
                     8'h15: dly_ff <= vx_ff;
                     8'h18: snd_ff <= vx_ff;
                     8'h1E: idx_ff <= idx_ff + {8'd0, vx_ff};
                     8'h29: idx_ff <= 16'(FONT_BASE) + 16'(vx_ff[3:0]) * 16'd5;
                     default: ;
                  endcase
               endcase
            end
            c8x_pkg::CMD_DRAWWR:
               if ((frd_ff & spr) != 64'd0) regs_ff[15] <= 8'd1;
            c8x_pkg::CMD_LOADWR: regs_ff[cmd.step[3:0]] <= mrd_ff;
            c8x_pkg::CMD_RESULT: begin
               if (act_ff == c8x_pkg::ACT_READ) rd_ff <= {56'd0, mrd_ff};
               else if (act_ff == c8x_pkg::ACT_ROW) rd_ff <= frd_ff;
            end
            default: ;
         endcase
      end
   end

   assign pc_now       = pc_ff;
   assign index_now    = idx_ff;
   assign flag_now     = regs_ff[15];
   assign awaiting_key = wait_ff;
   assign sound_on     = snd_ff != 8'd0;
   assign read_data    = rd_ff;
endmodule

### hw/rtl/c8x_control.sv
module c8x_control (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output c8x_pkg::cmd_type    cmd,
   input  c8x_pkg::status_type status
);
   localparam logic [3:0] S_FILL = 4'd0, S_IDLE = 4'd1, S_DISP = 4'd2, S_CLS = 4'd3,
      S_DRD = 4'd4, S_DWAIT = 4'd5, S_DWR = 4'd6, S_STORE = 4'd7, S_LRD = 4'd8,
      S_LWAIT = 4'd9, S_LWR = 4'd10, S_MRD = 4'd11, S_FIN = 4'd12, S_OUT = 4'd13;

   logic [3:0] st_ff, st_in;
   logic [6:0] step_ff, step_in;
   logic       rv_ff, rv_in;
   logic [4:0] last;

   assign req_ready = (st_ff == S_IDLE) && !rv_ff;
   assign rsp_valid = rv_ff;

   always_comb begin
      st_in = st_ff; step_in = step_ff; rv_in = rv_ff;
      cmd.cmd = c8x_pkg::CMD_NONE; cmd.step = step_ff;
      last = (status.kk == 8'h33) ? 5'd2 : {1'b0, status.x};
      if (rv_ff && rsp_ready) rv_in = 1'b0;
      case (st_ff)
         // one pass over the whole memory: zero, with the font at its base
         S_FILL: begin
            cmd.cmd = c8x_pkg::CMD_FILL;
            if (status.fill_last) begin st_in = S_IDLE; step_in = 7'd0; end
         end
         S_IDLE: if (req_valid && !rv_ff) begin
            cmd.cmd = c8x_pkg::CMD_LATCH; st_in = S_DISP; step_in = 7'd0;
         end
         S_DISP: case (status.action)
            c8x_pkg::ACT_EXEC: begin
               cmd.cmd = c8x_pkg::CMD_EXEC;
               st_in = S_OUT;
               if (status.top == 4'h0 && status.kk == 8'hE0 && status.x == 4'd0)
                  st_in = S_CLS;
               else if (status.top == 4'hD) st_in = (status.n == 4'd0) ? S_OUT : S_DRD;
               else if (status.top == 4'hF && (status.kk == 8'h55 || status.kk == 8'h33))
                  st_in = S_STORE;
               else if (status.top == 4'hF && status.kk == 8'h65) st_in = S_LRD;
            end
            c8x_pkg::ACT_WRITE: begin cmd.cmd = c8x_pkg::CMD_MEMWR; st_in = S_OUT; end
            c8x_pkg::ACT_READ:  begin cmd.cmd = c8x_pkg::CMD_MEMRD; st_in = S_MRD; end
            default:            begin cmd.cmd = c8x_pkg::CMD_ROWRD; st_in = S_MRD; end
         endcase
         S_CLS: begin
            cmd.cmd = c8x_pkg::CMD_CLS; step_in = step_ff + 7'd1;
            if (step_ff == 7'd31) st_in = S_OUT;
         end
         S_DRD: if (status.row_clip) st_in = S_OUT;
            else begin cmd.cmd = c8x_pkg::CMD_DRAWRD; st_in = S_DWAIT; end
         S_DWAIT: st_in = S_DWR;
         S_DWR: begin
            cmd.cmd = c8x_pkg::CMD_DRAWWR; step_in = step_ff + 7'd1;
            st_in = (step_ff[3:0] == status.n - 4'd1) ? S_OUT : S_DRD;
         end
         S_STORE: begin
            cmd.cmd = c8x_pkg::CMD_STORE; step_in = step_ff + 7'd1;
            if (step_ff[4:0] == last) st_in = S_OUT;
         end
         S_LRD:   begin cmd.cmd = c8x_pkg::CMD_LOADRD; st_in = S_LWAIT; end
         S_LWAIT: st_in = S_LWR;
         S_LWR: begin
            cmd.cmd = c8x_pkg::CMD_LOADWR; step_in = step_ff + 7'd1;
            st_in = (step_ff[3:0] == status.x) ? S_OUT : S_LRD;
         end
         S_MRD: st_in = S_FIN;
         S_FIN: begin cmd.cmd = c8x_pkg::CMD_RESULT; st_in = S_OUT; end
         S_OUT: begin rv_in = 1'b1; st_in = S_IDLE; end
         default: st_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= S_FILL; step_ff <= 7'd0; rv_ff <= 1'b0;
      end else begin
         st_ff <= st_in; step_ff <= step_in; rv_ff <= rv_in;
      end
   end
endmodule

### hw/rtl/c8x_checker.sv
module c8x_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [63:0] rsp_read_data
);
   // never accept a request while a result is pending
   a_one: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("request taken while result pending");
   // result waits for the receiver, its read data unchanged
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_read_data))
      else $error("result dropped");
   // a result never appears straight after an accept
   a_lat: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid) else $error("result too early");
endmodule

bind chip8_instruction_executor_top c8x_checker u_chk (.clock, .reset, .req_valid,
   .req_ready, .rsp_valid, .rsp_ready, .rsp_read_data);

### tb/sv/chip8_instruction_executor_top_test.sv
`timescale 1ns / 1ps

module chip8_instruction_executor_top_test;

   localparam int RANDOM_REQUESTS = 1030;
   localparam int CALM_TAIL       = 120;
   localparam int STALL_LIMIT     = 20000;

   typedef struct {
      logic [11:0] pc;
      logic [15:0] index;
      logic [7:0]  flag;
      logic        waiting;
      logic        sound;
      logic [63:0] data;
   } outcome_type;

   class c8_scoreboard;
      byte unsigned mem[4096];
      byte unsigned vreg[16];
      logic [11:0]  calls[16];
      bit           call_set[16];
      int unsigned  depth;
      logic [11:0]  pc;
      logic [15:0]  index;
      logic [63:0]  frame[32];
      byte unsigned delay_val, sound_val;
      outcome_type  pending[$];
      int           errors;
      int           n_exec, n_write, n_read, n_row, n_draw, n_calls;

      function new();
         byte unsigned font[80] = '{
            8'hF0,8'h90,8'h90,8'h90,8'hF0, 8'h20,8'h60,8'h20,8'h20,8'h70,
            8'hF0,8'h10,8'hF0,8'h80,8'hF0, 8'hF0,8'h10,8'hF0,8'h10,8'hF0,
            8'h90,8'h90,8'hF0,8'h10,8'h10, 8'hF0,8'h80,8'hF0,8'h10,8'hF0,
            8'hF0,8'h80,8'hF0,8'h90,8'hF0, 8'hF0,8'h10,8'h20,8'h40,8'h40,
            8'hF0,8'h90,8'hF0,8'h90,8'hF0, 8'hF0,8'h90,8'hF0,8'h10,8'hF0,
            8'hF0,8'h90,8'hF0,8'h90,8'h90, 8'hE0,8'h90,8'hE0,8'h90,8'hE0,
            8'hF0,8'h80,8'h80,8'h80,8'hF0, 8'hE0,8'h90,8'h90,8'h90,8'hE0,
            8'hF0,8'h80,8'hF0,8'h80,8'hF0, 8'hF0,8'h80,8'hF0,8'h80,8'h80};
         foreach (mem[a]) mem[a] = 0;
         for (int i = 0; i < 80; i++) mem[80 + i] = font[i];
         foreach (vreg[i]) vreg[i] = 0;
         foreach (call_set[i]) call_set[i] = 0;
         foreach (frame[i]) frame[i] = '0;
         depth = 0;
         pc = 12'h200;
         index = 0;
         delay_val = 0;
         sound_val = 0;
         errors = 0;
      endfunction

      // a return must only pop an entry that a call has filled
      function bit can_return();
         return call_set[(depth + 15) % 16];
      endfunction

      function void sprite(int x, int y, int n);
         int x0, y0, py, px;
         byte unsigned bits;
         logic [63:0] m;
         x0 = vreg[x] % 64;
         y0 = vreg[y] % 32;
         vreg[15] = 0;
         for (int r = 0; r < n; r++) begin
            bits = mem[(index + r) & 12'hFFF];
            py = y0 + r;
            if (py >= 32) break;
            for (int c = 0; c < 8; c++) begin
               px = x0 + c;
               if (px >= 64) break;
               if (bits[7 - c]) begin
                  m = 64'd1 << (63 - px);
                  if (frame[py] & m) vreg[15] = 1;
                  frame[py] ^= m;
               end
            end
         end
      endfunction

      function bit run_opcode(logic [15:0] op, logic [15:0] keys, byte unsigned rnd);
         int x, y, n;
         byte unsigned kk, vx, vy;
         x = op[11:8];
         y = op[7:4];
         n = op[3:0];
         kk = op[7:0];
         pc = pc + 12'd2;
         vx = vreg[x];
         vy = vreg[y];
         case (op[15:12])
            4'h0: begin
               if (op == 16'h00E0) begin
                  foreach (frame[i]) frame[i] = '0;
               end else if (op == 16'h00EE) begin
                  depth = (depth + 15) % 16;
                  pc = calls[depth];
                  n_calls++;
               end
            end
            4'h1: pc = op[11:0];
            4'h2: begin
               calls[depth] = pc;
               call_set[depth] = 1;
               depth = (depth + 1) % 16;
               pc = op[11:0];
               n_calls++;
            end
            4'h3: if (vx == kk) pc += 12'd2;
            4'h4: if (vx != kk) pc += 12'd2;
            4'h5: if (n == 0 && vx == vy) pc += 12'd2;
            4'h6: vreg[x] = kk;
            4'h7: vreg[x] = vx + kk;
            4'h8: begin
               case (n)
                  0: vreg[x] = vy;
                  1: vreg[x] = vx | vy;
                  2: vreg[x] = vx & vy;
                  3: vreg[x] = vx ^ vy;
                  4: begin vreg[15] = (int'(vx) + vy > 255); vreg[x] = vx + vy; end
                  5: begin vreg[15] = (vx > vy); vreg[x] = vx - vy; end
                  6: begin vreg[15] = vx & 8'd1; vreg[x] = vx >> 1; end
                  7: begin vreg[15] = (vy > vx); vreg[x] = vy - vx; end
                  14: begin vreg[15] = vx >> 7; vreg[x] = vx << 1; end
                  default: ;
               endcase
            end
            4'h9: if (n == 0 && vx != vy) pc += 12'd2;
            4'hA: index = {4'd0, op[11:0]};
            4'hB: pc = op[11:0] + vreg[0];
            4'hC: vreg[x] = rnd & kk;
            4'hD: begin sprite(x, y, n); n_draw++; end
            4'hE: begin
               if (kk == 8'h9E && keys[vx[3:0]]) pc += 12'd2;
               else if (kk == 8'hA1 && !keys[vx[3:0]]) pc += 12'd2;
            end
            default: begin
               case (kk)
                  8'h07: vreg[x] = delay_val;
                  8'h0A: begin
                     for (int i = 0; i < 16; i++)
                        if (keys[i]) begin
                           vreg[x] = 8'(i);
                           return 0;
                        end
                     pc = pc - 12'd2;
                     return 1;
                  end
                  8'h15: delay_val = vx;
                  8'h18: sound_val = vx;
                  8'h1E: index = index + vx;
                  8'h29: index = 16'd80 + 16'(vx[3:0]) * 16'd5;
                  8'h33: begin
                     mem[index[11:0]] = vx / 8'd100;
                     mem[(index + 1) & 12'hFFF] = (vx / 8'd10) % 8'd10;
                     mem[(index + 2) & 12'hFFF] = vx % 8'd10;
                  end
                  8'h55: for (int i = 0; i <= x; i++) mem[(index + i) & 12'hFFF] = vreg[i];
                  8'h65: for (int i = 0; i <= x; i++) vreg[i] = mem[(index + i) & 12'hFFF];
                  default: ;
               endcase
            end
         endcase
         return 0;
      endfunction

      function void note_request(logic [1:0] act, logic [15:0] op, logic [15:0] keys,
                                 logic [7:0] rnd, logic [11:0] addr, logic [7:0] wdata,
                                 logic [4:0] row);
         outcome_type o;
         o.data = '0;
         o.waiting = 0;
         case (act)
            c8x_pkg::ACT_EXEC:  begin o.waiting = run_opcode(op, keys, rnd); n_exec++; end
            c8x_pkg::ACT_WRITE: begin mem[addr] = wdata; n_write++; end
            c8x_pkg::ACT_READ:  begin o.data = {56'd0, mem[addr]}; n_read++; end
            default:            begin o.data = frame[row]; n_row++; end
         endcase
         o.pc = pc;
         o.index = index;
         o.flag = vreg[15];
         o.sound = (sound_val != 0);
         pending.push_back(o);
      endfunction

      task report(string msg);
         $display("MISMATCH @%0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(outcome_type got);
         outcome_type want;
         if (pending.size() == 0) begin
            report("result with no request outstanding");
            return;
         end
         want = pending.pop_front();
         if (got.pc !== want.pc) report($sformatf("pc %h, want %h", got.pc, want.pc));
         if (got.index !== want.index)
            report($sformatf("index %h, want %h", got.index, want.index));
         if (got.flag !== want.flag) report($sformatf("VF %h, want %h", got.flag, want.flag));
         if (got.waiting !== want.waiting)
            report($sformatf("awaiting_key %b, want %b", got.waiting, want.waiting));
         if (got.sound !== want.sound)
            report($sformatf("sound_on %b, want %b", got.sound, want.sound));
         if (got.data !== want.data)
            report($sformatf("read_data %h, want %h", got.data, want.data));
      endtask
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_action = c8x_pkg::ACT_EXEC;
   logic [15:0] req_opcode = '0;
   logic [15:0] req_keys_down = '0;
   logic [7:0]  req_random_byte = '0;
   logic [11:0] req_mem_addr = '0;
   logic [7:0]  req_mem_data = '0;
   logic [4:0]  req_row_select = '0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [11:0] rsp_pc_now;
   logic [15:0] rsp_index_now;
   logic [7:0]  rsp_flag_now;
   logic        rsp_awaiting_key;
   logic        rsp_sound_on;
   logic [63:0] rsp_read_data;

   c8_scoreboard sb = new();
   bit calm = 0;
   int quiet_cycles = 0;

   chip8_instruction_executor_top uut (.*);

   always begin
      #1 clock = 1;
      #1 clock = 0;
   end

   always @(posedge clock) begin
      outcome_type got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.pc = rsp_pc_now;
         got.index = rsp_index_now;
         got.flag = rsp_flag_now;
         got.waiting = rsp_awaiting_key;
         got.sound = rsp_sound_on;
         got.data = rsp_read_data;
         sb.check_result(got);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("** chip8_instruction_executor_top: FAILED **");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // receiver back-pressure in bursts
   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            hold--;
            rsp_ready = 0;
         end else if (!calm && $urandom_range(0, 7) == 0) begin
            hold = $urandom_range(1, 15) - 1;
            rsp_ready = 0;
         end else begin
            rsp_ready = 1;
         end
      end
   end

   task send(logic [1:0] act, logic [15:0] op, logic [15:0] keys = 16'h0000,
             logic [7:0] rnd = 8'h00, logic [11:0] addr = 12'h000,
             logic [7:0] wdata = 8'h00, logic [4:0] row = 5'd0);
      req_action = act;
      req_opcode = op;
      req_keys_down = keys;
      req_random_byte = rnd;
      req_mem_addr = addr;
      req_mem_data = wdata;
      req_row_select = row;
      req_valid = 1;
      do @(posedge clock); while (!req_ready);
      sb.note_request(act, op, keys, rnd, addr, wdata, row);
      @(negedge clock);
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_valid = 0;
         repeat ($urandom_range(1, 15)) @(negedge clock);
      end
   endtask

   task exec(logic [15:0] op, logic [15:0] keys = 16'h0000, logic [7:0] rnd = 8'h00);
      send(c8x_pkg::ACT_EXEC, op, keys, rnd);
   endtask

   task drain();
      req_valid = 0;
      while (sb.pending.size() != 0) @(negedge clock);
   endtask

   function logic [15:0] pick_opcode();
      logic [31:0] r;
      logic [15:0] op;
      byte unsigned fx[9] = '{8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33, 8'h55, 8'h65};
      r = $urandom();
      op = {r[15:12], r[11:0]};
      case (op[15:12])
         4'h0: case (r[17:16])
                  2'd0, 2'd1: op = 16'h00EE;
                  2'd2: op = 16'h00E0;
                  default: ;
               endcase
         4'h5, 4'h9: if (r[18:16] != 0) op[3:0] = 0;
         4'hE: case (r[17:16])
                  2'd0: op[7:0] = 8'h9E;
                  2'd1: op[7:0] = 8'hA1;
                  default: ;
               endcase
         4'hF: if (r[19:16] != 0) op[7:0] = fx[r[23:20] % 9];
         default: ;
      endcase
      if (op == 16'h00EE && !sb.can_return()) op = {4'h2, r[27:16]};
      return op;
   endfunction

   initial begin
      logic [31:0] r;
      logic [15:0] keys;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // edges of the memory and display ports, font readback
      send(c8x_pkg::ACT_WRITE, 16'h0, 16'h0, 8'h0, 12'hFFF, 8'hFF);
      send(c8x_pkg::ACT_READ, 16'hFFFF, 16'hFFFF, 8'hFF, 12'hFFF);
      send(c8x_pkg::ACT_READ, 16'h0, 16'h0, 8'h0, 12'h050);
      send(c8x_pkg::ACT_READ, 16'h0, 16'h0, 8'h0, 12'h000);
      exec(16'h603C);
      exec(16'h611E);
      exec(16'hA050);
      exec(16'hD01F);          // clipped at right and bottom edges
      exec(16'hD01F);          // collision
      send(c8x_pkg::ACT_ROW, 16'h0, 16'h0, 8'h0, 12'h0, 8'h0, 5'd31);
      send(c8x_pkg::ACT_ROW, 16'h0, 16'h0, 8'h0, 12'h0, 8'h0, 5'd30);
      exec(16'h62FF);
      exec(16'h8F24);          // VF as destination of an add with carry
      exec(16'h8125);
      exec(16'h8F2E);
      exec(16'h8127);
      exec(16'h8F26);
      exec(16'h60FF);
      exec(16'hBFFF);          // PC wraps
      exec(16'h2FFE);
      exec(16'h00EE);
      exec(16'h00EE);          // underflow wraps the stack level
      exec(16'hF00A);          // no key: PC rewound
      exec(16'hF30A, 16'h8000);
      exec(16'hF218);
      exec(16'hAFFF);
      exec(16'hF233);          // BCD wraps round memory
      exec(16'hFF55);
      exec(16'hFF65);
      exec(16'hE39E, 16'h8000);
      exec(16'hE3A1, 16'h7FFF);
      exec(16'hC5AA, 16'h0, 8'hFF);
      exec(16'h00E0);
      drain();

      for (int i = 0; i < RANDOM_REQUESTS; i++) begin
         if (i == RANDOM_REQUESTS / 2) drain();
         if (i == RANDOM_REQUESTS - CALM_TAIL) calm = 1;
         r = $urandom();
         keys = (r[1:0] == 0) ? 16'h0000 : (r[1:0] == 1) ? (16'd1 << r[7:4]) :
                16'($urandom());
         case ($urandom_range(0, 9))
            0: send(c8x_pkg::ACT_WRITE, 16'($urandom()), keys, 8'($urandom()),
                    12'($urandom()), 8'($urandom()), 5'($urandom()));
            1: send(c8x_pkg::ACT_READ, 16'($urandom()), keys, 8'($urandom()),
                    12'($urandom()), 8'($urandom()), 5'($urandom()));
            2: send(c8x_pkg::ACT_ROW, 16'($urandom()), keys, 8'($urandom()),
                    12'($urandom()), 8'($urandom()), 5'($urandom()));
            default: send(c8x_pkg::ACT_EXEC, pick_opcode(), keys, 8'($urandom()),
                          12'($urandom()), 8'($urandom()), 5'($urandom()));
         endcase
      end
      req_valid = 0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Ran %0d executes (%0d draws, %0d calls/returns), %0d writes, %0d reads,",
               sb.n_exec, sb.n_draw, sb.n_calls, sb.n_write, sb.n_read);
      $display("%0d display row reads; %0d mismatches", sb.n_row, sb.errors);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("** chip8_instruction_executor_top: PASSED **");
      end else begin
         $display("** chip8_instruction_executor_top: FAILED **");
      end
      $finish;
   end

endmodule
